// ===== hw/rtl/actm_pkg.sv =====
// Shared constants, types and calibration tables for the calibrated trimmed mean block.
// Used by actm_div and adc_calibrated_trimmed_mean; depends on nothing else.
package actm_pkg;

  // Sizing of the block.
  localparam int WINDOW_LENGTH = 50;
  localparam int CHANNEL_COUNT = 6;
  localparam int CAL_SEGMENTS  = 16;
  localparam int ROM_SIZE      = 16;
  localparam int CAL_LIMIT     = (CAL_SEGMENTS < ROM_SIZE) ? CAL_SEGMENTS : ROM_SIZE;

  // Field widths.
  localparam int CH_W     = 3;
  localparam int RAW_W    = 32;
  localparam int VAL_W    = 13;
  localparam int GAIN_W   = 8;
  localparam int SAMPLE_W = 15;
  localparam int FACTOR_W = 8;

  // Window indexing and accumulation widths.
  localparam int IDX_W     = $clog2(WINDOW_LENGTH);
  localparam int CNT_W     = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W     = VAL_W + CNT_W;
  localparam int CH_IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int RAM_DEPTH = CHANNEL_COUNT * WINDOW_LENGTH;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // Shared multiplier: 21 x 32 bits, product registered.
  localparam int MUL_A_W     = 21;
  localparam int MUL_B_W     = 32;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int SCALE_SHIFT = 12;
  localparam int RECIP_SHIFT = 37;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  localparam logic [MUL_B_W-1:0] SCALE_MUL  = 32'd1000;
  // Reciprocal of 100 scaled by 2^37; exact floor division for 32-bit operands.
  localparam logic [MUL_B_W-1:0] RECIP_100  = 32'd1374389535;
  localparam logic [VAL_W-1:0]   VALUE_MAX  = 13'd7999;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 8'd48;

  // Channel codes: CH_NARROW and CAL_CH_COUNT are zero based, CH_LAST is one based.
  localparam logic [CH_W-1:0] CH_NARROW    = 3'd1;
  localparam logic [CH_W-1:0] CAL_CH_COUNT = 3'd4;
  localparam logic [CH_W-1:0] CH_LAST      = 3'd6;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic                hit;
    logic [FACTOR_W-1:0] factor;
  } cal_sel_t;

  // Segment thresholds, shared by all calibrated channels.
  localparam val_t CAL_THRESH [ROM_SIZE] = '{
    13'd7,   13'd37,  13'd59,  13'd81,  13'd104, 13'd126, 13'd149, 13'd196,
    13'd293, 13'd383, 13'd477, 13'd571, 13'd658, 13'd758, 13'd849, 13'd926
  };

  // Percentage factors, one row per calibrated channel.
  localparam logic [FACTOR_W-1:0] CAL_FACTOR [4][ROM_SIZE] = '{
    '{8'd0, 8'd68, 8'd85, 8'd93, 8'd96, 8'd99, 8'd101, 8'd102,
      8'd102, 8'd104, 8'd105, 8'd105, 8'd106, 8'd106, 8'd106, 8'd108},
    '{8'd0, 8'd68, 8'd88, 8'd93, 8'd96, 8'd99, 8'd101, 8'd102,
      8'd102, 8'd104, 8'd105, 8'd105, 8'd106, 8'd106, 8'd106, 8'd108},
    '{8'd0, 8'd68, 8'd85, 8'd93, 8'd96, 8'd99, 8'd101, 8'd102,
      8'd102, 8'd104, 8'd105, 8'd105, 8'd106, 8'd106, 8'd106, 8'd108},
    '{8'd0, 8'd68, 8'd83, 8'd93, 8'd96, 8'd99, 8'd101, 8'd102,
      8'd102, 8'd104, 8'd105, 8'd105, 8'd106, 8'd106, 8'd106, 8'd108}
  };

  // Find the first threshold above t; the factor is the entry just before it.
  function automatic cal_sel_t cal_lookup(input logic [1:0] cal_ch, input val_t t);
    cal_sel_t sel;
    sel.hit    = 1'b0;
    sel.factor = '0;
    for (int i = CAL_LIMIT - 1; i >= 1; i--) begin
      if (t < CAL_THRESH[i]) begin
        sel.hit    = 1'b1;
        sel.factor = CAL_FACTOR[cal_ch][i-1];
      end
    end
    return sel;
  endfunction

endpackage

// ===== hw/rtl/actm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the per-channel sample windows of the trimmed mean block.
module actm_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 300
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/actm_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, for the window mean.
// Depends on actm_pkg for the sum and count widths.
module actm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [actm_pkg::SUM_W-1:0] dividend,
  input  logic [actm_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [actm_pkg::SUM_W-1:0] quotient
);
  import actm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    trial;
  logic              fits;

  // One trial subtraction per cycle.
  always_comb begin
    rem_shift = {rem_r, quo_r[SUM_W-1]};
    trial     = rem_shift - {1'b0, div_r};
    fits      = (rem_shift >= {1'b0, div_r});
  end

  // Iteration control.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = fits ? trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/adc_calibrated_trimmed_mean.sv =====
// Top level of the calibrated trimmed mean block: sequencer, shared multiplier, window scan.
// Depends on actm_pkg, actm_ram (sample windows) and actm_div (mean division).
//
// Usage:
//   The input channel carries a channel number (1..6) and a raw converter word; one
//   transfer happens when in_valid is high and in_stall is low. Each accepted item
//   produces exactly one result on the output channel, transferred when out_valid is
//   high and out_stall is low. The gain register for channels 5 and 6 is written by
//   pulsing cfg_wr_en with the new value; write it only while the block is idle.
//   An item with an invalid channel or an empty word skips the value path and goes
//   straight to S_OUT with a zero result. A valid item passes through three multiplier
//   steps for scaling and correction, a window write, a scan that issues one RAM read
//   per window entry and folds in each entry once its read data is registered, then
//   the divider, which finds one quotient bit per cycle, and a step that collects the
//   quotient. A flat window or one with nothing left to count skips the divider.
//   in_stall stays high while an item is in work. After reset the windows read as zero
//   through per-channel fill tracking, so no clearing pass is needed and the gain is 48.
//   While out_stall holds a finished result, the next result waits inside the block
//   until the output register frees.
module adc_calibrated_trimmed_mean (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [actm_pkg::CH_W-1:0]   in_channel_number,
  input  logic [actm_pkg::RAW_W-1:0]  in_raw_result,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [actm_pkg::VAL_W-1:0]  out_filtered_value,
  input  logic                        cfg_wr_en,
  input  logic [actm_pkg::GAIN_W-1:0] cfg_direct_gain_percent
);
  import actm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCALE  = 4'd1;
  localparam logic [3:0] S_CAL    = 4'd2;
  localparam logic [3:0] S_RECIP  = 4'd3;
  localparam logic [3:0] S_WRITE  = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_TRIM   = 4'd6;
  localparam logic [3:0] S_DIVIDE = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [IDX_W-1:0]  WL_LAST = IDX_W'(WINDOW_LENGTH - 1);
  localparam logic [CNT_W-1:0]  WL_CNT  = CNT_W'(WINDOW_LENGTH);
  localparam logic [ADDR_W-1:0] WL_ADDR = ADDR_W'(WINDOW_LENGTH);

  // Sequencer and datapath registers.
  logic [3:0]          state_r, state_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  val_t                val_r, val_nxt;
  logic                bypass_r, bypass_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  val_t                max_r, max_nxt;
  val_t                min_r, min_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  val_t                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  val_t                out_value_r, out_value_nxt;

  // Per-channel write position and wrap flag.
  logic [IDX_W-1:0]    pos_r [CHANNEL_COUNT];
  logic                filled_r [CHANNEL_COUNT];
  logic [IDX_W-1:0]    pos_nxt;
  logic                filled_nxt;
  logic                pos_upd;

  // Shared multiplier operands.
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;

  // Helpers.
  logic [CH_IDX_W-1:0] chi;
  logic [CH_W-1:0]     in_ch;
  logic                chan_ok;
  logic                word_ok;
  val_t                scaled;
  cal_sel_t            cal_sel;
  logic [QUO_W-1:0]    quo100;
  val_t                new_val;
  val_t                entry;
  logic                entry_ok;
  logic                min_nz;
  logic [SUM_W-1:0]    sum_adj;
  logic [CNT_W-1:0]    cnt_adj;
  logic                out_free;

  // RAM and divider connections.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  val_t                ram_rdata;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;

  actm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (RAM_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (new_val),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  actm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_adj),
    .divisor  (cnt_adj),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Input checks on the incoming item.
  always_comb begin
    in_ch   = in_channel_number - 1'b1;
    chan_ok = (in_channel_number inside {[3'd1:CH_LAST]}) &&
              (int'(in_channel_number) <= CHANNEL_COUNT);
    word_ok = (in_raw_result[RAW_W-2:0] != '0);
  end

  // Value path helpers: scaling result, calibration lookup, divide by 100.
  always_comb begin
    chi     = ch_r[CH_IDX_W-1:0];
    scaled  = prod_r[SCALE_SHIFT +: VAL_W];
    cal_sel = cal_lookup(ch_r[1:0], scaled);
    quo100  = prod_r[RECIP_SHIFT +: QUO_W];
    if (bypass_r) begin
      new_val = val_r;
    end else if (quo100 > QUO_W'(VALUE_MAX)) begin
      new_val = VALUE_MAX;
    end else begin
      new_val = quo100[VAL_W-1:0];
    end
  end

  // Window entry seen by the scan; entries never written read as zero.
  always_comb begin
    entry_ok = filled_r[chi] || (rd_idx_r < pos_r[chi]);
    entry    = entry_ok ? ram_rdata : '0;
  end

  // Trim the first maximum and, if it is nonzero, the first minimum out of the sum and count.
  always_comb begin
    min_nz  = (min_r != '0);
    sum_adj = sum_r - SUM_W'(max_r) - (min_nz ? SUM_W'(min_r) : '0);
    cnt_adj = cnt_r - CNT_W'(1) - (min_nz ? CNT_W'(1) : '0);
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    base_nxt      = base_r;
    sample_nxt    = sample_r;
    prod_nxt      = prod_r;
    val_nxt       = val_r;
    bypass_nxt    = bypass_r;
    gain_nxt      = cfg_wr_en ? cfg_direct_gain_percent : gain_r;
    scan_idx_nxt  = scan_idx_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    mul_a         = '0;
    mul_b         = '0;
    ram_we        = 1'b0;
    ram_waddr     = base_r + ADDR_W'(pos_r[chi]);
    ram_raddr     = base_r + ADDR_W'(scan_idx_r[IDX_W-1:0]);
    pos_upd       = 1'b0;
    pos_nxt       = (pos_r[chi] == WL_LAST) ? '0 : pos_r[chi] + 1'b1;
    filled_nxt    = filled_r[chi] || (pos_r[chi] == WL_LAST);
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt   = in_ch;
          base_nxt = ADDR_W'(in_ch) * WL_ADDR;
          if (in_ch == CH_NARROW) begin
            sample_nxt = SAMPLE_W'(in_raw_result[15:4]);
          end else begin
            sample_nxt = in_raw_result[18:4];
          end
          if (chan_ok && word_ok) begin
            state_nxt = S_SCALE;
          end else begin
            res_nxt   = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_SCALE: begin
        // Raw sample times 1000; the shift by 12 is taken in the next step.
        mul_a     = MUL_A_W'(sample_r);
        mul_b     = SCALE_MUL;
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_CAL;
      end
      S_CAL: begin
        // Apply the calibration factor or the direct gain.
        val_nxt = scaled;
        mul_a   = MUL_A_W'(scaled);
        if (ch_r < CAL_CH_COUNT) begin
          bypass_nxt = !cal_sel.hit;
          mul_b      = MUL_B_W'(cal_sel.factor);
        end else begin
          bypass_nxt = 1'b0;
          mul_b      = MUL_B_W'(gain_r);
        end
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_RECIP;
      end
      S_RECIP: begin
        // Divide by 100 through the scaled reciprocal.
        mul_a     = prod_r[MUL_A_W-1:0];
        mul_b     = RECIP_100;
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ram_we       = 1'b1;
        pos_upd      = 1'b1;
        scan_idx_nxt = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        // Issue one read per cycle, fold in the entry whose read was issued in the previous cycle.
        if (scan_idx_r < WL_CNT) begin
          rd_pend_nxt  = 1'b1;
          rd_idx_nxt   = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (rd_pend_r) begin
          if (rd_idx_r == '0) begin
            max_nxt = entry;
            min_nxt = entry;
            sum_nxt = SUM_W'(entry);
            cnt_nxt = (entry != '0) ? CNT_W'(1) : '0;
          end else begin
            if (entry > max_r) begin
              max_nxt = entry;
            end
            if (entry < min_r) begin
              min_nxt = entry;
            end
            sum_nxt = sum_r + SUM_W'(entry);
            cnt_nxt = cnt_r + ((entry != '0) ? CNT_W'(1) : '0);
          end
          if (rd_idx_r == WL_LAST) begin
            state_nxt = S_TRIM;
          end
        end
      end
      S_TRIM: begin
        if (max_r == min_r) begin
          res_nxt   = max_r;
          state_nxt = S_OUT;
        end else if (cnt_adj == '0) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          res_nxt   = div_quo[VAL_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      gain_r      <= GAIN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      gain_r      <= gain_nxt;
    end
  end

  // Per-channel fill tracking, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        pos_r[c]    <= '0;
        filled_r[c] <= 1'b0;
      end
    end else if (pos_upd) begin
      pos_r[chi]    <= pos_nxt;
      filled_r[chi] <= filled_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ch_r        <= ch_nxt;
    base_r      <= base_nxt;
    sample_r    <= sample_nxt;
    prod_r      <= prod_nxt;
    val_r       <= val_nxt;
    bypass_r    <= bypass_nxt;
    scan_idx_r  <= scan_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    max_r       <= max_nxt;
    min_r       <= min_nxt;
    sum_r       <= sum_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;

endmodule
